[design/rzsm_pkg.sv]
`default_nettype none
package rzsm_pkg;

   localparam int TRIG_BITS      = 24;
   localparam int COORD_BITS_DEF = 12;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int QUEUE_DEPTH    = 8;
   localparam int CSR_IDX_BITS   = 3;
   localparam int CSR_DATA_BITS  = TRIG_BITS;

   localparam logic [TRIG_BITS-1:0] COS_RESET = 24'd65536;
   localparam int                   DIM_RESET = 4096;
   localparam int                   STRIDE_RESET = 4096;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_COS_SCALED   = 3'd0,
      CSR_SIN_SCALED   = 3'd1,
      CSR_CENTER_X     = 3'd2,
      CSR_CENTER_Y     = 3'd3,
      CSR_IMAGE_WIDTH  = 3'd4,
      CSR_IMAGE_HEIGHT = 3'd5,
      CSR_ROW_STRIDE   = 3'd6,
      CSR_WRAP_MODE    = 3'd7
   } csr_index_type;

endpackage
`default_nettype wire

[design/rzsm_front.sv]
`default_nettype none
module rzsm_front #(
   parameter int COORD_BITS = 12,
   parameter int FRAC_BITS  = 16,
   parameter int VW         = 23
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire signed [rzsm_pkg::TRIG_BITS-1:0]  cos_scaled,
   input  wire signed [rzsm_pkg::TRIG_BITS-1:0]  sin_scaled,
   input  wire        [COORD_BITS-1:0]           center_x,
   input  wire        [COORD_BITS-1:0]           center_y,
   input  wire                                   in_valid,
   input  wire        [COORD_BITS-1:0]           dest_x,
   input  wire        [COORD_BITS-1:0]           dest_y,
   output logic                                  out_valid,
   output logic       [VW-1:0]                   xs,
   output logic       [VW-1:0]                   ys
);
   import rzsm_pkg::*;

   localparam int PROD_W = TRIG_BITS + COORD_BITS + 1;
   localparam int SUM_W  = PROD_W + 1;
   localparam int TR_W   = SUM_W - FRAC_BITS;

   logic [3:0] valid_ff;
   logic signed [COORD_BITS:0] dx_ff, dy_ff, dx_in, dy_in;
   logic signed [PROD_W-1:0] pcx_ff, psy_ff, psx_ff, pcy_ff;
   logic signed [PROD_W-1:0] pcx_in, psy_in, psx_in, pcy_in;
   logic signed [SUM_W-1:0] sumx_ff, sumy_ff, sumx_in, sumy_in;
   logic signed [SUM_W-1:0] biasx, biasy;
   logic [TR_W-1:0] tx, ty;
   logic [VW-1:0] xs_ff, ys_ff, xs_in, ys_in;

   always_comb begin
      dx_in  = $signed({1'b0, dest_x}) - $signed({1'b0, center_x});
      dy_in  = $signed({1'b0, dest_y}) - $signed({1'b0, center_y});
      pcx_in = cos_scaled * dx_ff;
      psy_in = sin_scaled * dy_ff;
      psx_in = sin_scaled * dx_ff;
      pcy_in = cos_scaled * dy_ff;
      sumx_in = pcx_ff - psy_ff;
      sumy_in = psx_ff + pcy_ff;
      // bias negative sums so the shift truncates toward zero
      biasx = sumx_ff + $signed({{(SUM_W-FRAC_BITS){1'b0}}, {FRAC_BITS{sumx_ff[SUM_W-1]}}});
      biasy = sumy_ff + $signed({{(SUM_W-FRAC_BITS){1'b0}}, {FRAC_BITS{sumy_ff[SUM_W-1]}}});
      tx = biasx[SUM_W-1:FRAC_BITS];
      ty = biasy[SUM_W-1:FRAC_BITS];
      xs_in = {{(VW-TR_W){tx[TR_W-1]}}, tx} + {{(VW-COORD_BITS){1'b0}}, center_x};
      ys_in = {{(VW-TR_W){ty[TR_W-1]}}, ty} + {{(VW-COORD_BITS){1'b0}}, center_y};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[2:0], in_valid};
      end
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      pcx_ff  <= pcx_in;
      psy_ff  <= psy_in;
      psx_ff  <= psx_in;
      pcy_ff  <= pcy_in;
      sumx_ff <= sumx_in;
      sumy_ff <= sumy_in;
      xs_ff   <= xs_in;
      ys_ff   <= ys_in;
   end

   assign out_valid = valid_ff[3];
   assign xs        = xs_ff;
   assign ys        = ys_ff;

endmodule
`default_nettype wire

[design/rzsm_queue.sv]
`default_nettype none
module rzsm_queue #(
   parameter int WIDTH = 46,
   parameter int DEPTH = 8
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              push,
   input  wire  [WIDTH-1:0] push_data,
   input  wire              pop,
   output logic             not_empty,
   output logic [WIDTH-1:0] head_data
);
   localparam int PTR_W = $clog2(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [PTR_W:0]   count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (push && !pop) count_ff <= count_ff + 1'b1;
         else if (pop && !push) count_ff <= count_ff - 1'b1;
      end
      if (push) mem_ff[wr_ptr_ff] <= push_data;
   end

   assign not_empty = (count_ff != '0);
   assign head_data = mem_ff[rd_ptr_ff];

endmodule
`default_nettype wire

[design/rzsm_back.sv]
`default_nettype none
module rzsm_back #(
   parameter int COORD_BITS = 12,
   parameter int VW         = 23
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire  [COORD_BITS:0]       image_width,
   input  wire  [COORD_BITS:0]       image_height,
   input  wire  [COORD_BITS+1:0]     row_stride,
   input  wire                       wrap_mode,
   input  wire                       in_valid,
   input  wire  [VW-1:0]             xs,
   input  wire  [VW-1:0]             ys,
   output logic                      in_take,
   output logic                      out_valid,
   input  wire                       out_stall,
   output logic [COORD_BITS-1:0]     src_x,
   output logic [COORD_BITS-1:0]     src_y,
   output logic [2*COORD_BITS:0]     src_address,
   output logic                      use_fill
);
   localparam int C = COORD_BITS;

   typedef struct packed {
      logic          neg;
      logic [VW-1:0] mag;
      logic [C:0]    rem;
      logic [C-1:0]  low;
   } axis_type;

   typedef struct packed {
      logic            in_image;
      axis_type [1:0]  ax;
   } stage_type;

   logic              advance;
   logic [C:0]        dim [2];
   logic [VW-1:0]     v [2];
   stage_type         st_in [VW+1];
   stage_type         st_ff [VW+1];
   logic [VW:0]       valid_ff;
   logic [C:0]        wrapped [2];
   logic [C-1:0]      coord_in [2];
   logic              fill_in;
   logic              fix_valid_ff, fill_ff;
   logic [C-1:0]      fx_ff, fy_ff;
   logic [2*C+2:0]    addr_full;
   logic              out_valid_ff, use_fill_ff;
   logic [C-1:0]      src_x_ff, src_y_ff;
   logic [2*C:0]      src_address_ff;

   function automatic axis_type div_step(axis_type a, logic [C:0] d);
      logic [C+1:0] t;
      axis_type     r;
      t = {a.rem, a.mag[VW-1]};
      if (t >= {1'b0, d}) t = t - {1'b0, d};
      r     = a;
      r.rem = t[C:0];
      r.mag = {a.mag[VW-2:0], 1'b0};
      return r;
   endfunction

   assign advance = !(out_valid_ff && out_stall);
   assign in_take = in_valid && advance;

   always_comb begin
      // saturate sizes above the coordinate range
      dim[0] = (image_width[C] && (image_width[C-1:0] != '0))
               ? {1'b1, {C{1'b0}}} : image_width;
      dim[1] = (image_height[C] && (image_height[C-1:0] != '0))
               ? {1'b1, {C{1'b0}}} : image_height;
      v[0] = xs;
      v[1] = ys;
      st_in[0].in_image = 1'b1;
      for (int a = 0; a < 2; a++) begin
         st_in[0].ax[a].neg = v[a][VW-1];
         st_in[0].ax[a].mag = v[a][VW-1] ? (~v[a] + 1'b1) : v[a];
         st_in[0].ax[a].rem = '0;
         st_in[0].ax[a].low = v[a][C-1:0];
         if (v[a][VW-1] || !(v[a] < {{(VW-C-1){1'b0}}, dim[a]}))
            st_in[0].in_image = 1'b0;
      end
      for (int k = 1; k <= VW; k++) begin
         st_in[k].in_image = st_ff[k-1].in_image;
         for (int a = 0; a < 2; a++) begin
            st_in[k].ax[a] = div_step(st_ff[k-1].ax[a], dim[a]);
         end
      end
      for (int a = 0; a < 2; a++) begin
         if (dim[a] == '0) wrapped[a] = '0;
         else if (st_ff[VW].ax[a].neg && st_ff[VW].ax[a].rem != '0)
            wrapped[a] = dim[a] - st_ff[VW].ax[a].rem;
         else wrapped[a] = st_ff[VW].ax[a].rem;
      end
      fill_in = !wrap_mode && !st_ff[VW].in_image;
      for (int a = 0; a < 2; a++) begin
         if (wrap_mode) coord_in[a] = wrapped[a][C-1:0];
         else if (fill_in) coord_in[a] = '0;
         else coord_in[a] = st_ff[VW].ax[a].low;
      end
      addr_full = fy_ff * row_stride + fx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         fix_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff     <= {valid_ff[VW-1:0], in_valid};
         fix_valid_ff <= valid_ff[VW];
         out_valid_ff <= fix_valid_ff;
      end
      if (advance) begin
         for (int k = 0; k <= VW; k++) st_ff[k] <= st_in[k];
         fx_ff           <= coord_in[0];
         fy_ff           <= coord_in[1];
         fill_ff         <= fill_in;
         src_x_ff        <= fx_ff;
         src_y_ff        <= fy_ff;
         src_address_ff  <= addr_full[2*C:0];
         use_fill_ff     <= fill_ff;
      end
   end

   assign out_valid   = out_valid_ff;
   assign src_x       = src_x_ff;
   assign src_y       = src_y_ff;
   assign src_address = src_address_ff;
   assign use_fill    = use_fill_ff;

endmodule
`default_nettype wire

[design/rotate_zoom_source_mapper.sv]
`default_nettype none
// Channel   Direction  Handshake            Beat contents
// req_      in         req_valid/req_stall  dest_x, dest_y
// rsp_      out        rsp_valid/rsp_stall  src_x, src_y, src_address, use_fill
// csr_      in         csr_write_enable     csr_index, csr_data
//
// One beat per cycle sustained while rsp_stall is low; a beat passes the front
// pipeline, the queue, then the back end, whose modulo pipeline takes one bit
// per stage over VW = TRIG_BITS + COORD_BITS + 3 - FRAC_BITS (23 at defaults).
// Reset is synchronous, active high, and clears all control state.
// A stalled result freezes the back end; the front keeps draining into the
// queue, and req_stall rises once queued plus in-flight beats reach its depth.
module rotate_zoom_source_mapper #(
   parameter int COORD_BITS = rzsm_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = rzsm_pkg::FRAC_BITS_DEF
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   output logic                                req_stall,
   input  wire  [COORD_BITS-1:0]               req_dest_x,
   input  wire  [COORD_BITS-1:0]               req_dest_y,
   output logic                                rsp_valid,
   input  wire                                 rsp_stall,
   output logic [COORD_BITS-1:0]               rsp_src_x,
   output logic [COORD_BITS-1:0]               rsp_src_y,
   output logic [2*COORD_BITS:0]               rsp_src_address,
   output logic                                rsp_use_fill,
   input  wire                                 csr_write_enable,
   input  wire  [rzsm_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  wire  [rzsm_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import rzsm_pkg::*;

   localparam int VW    = TRIG_BITS + COORD_BITS + 3 - FRAC_BITS;
   localparam int CRD_W = $clog2(QUEUE_DEPTH) + 1;

   logic signed [TRIG_BITS-1:0] cos_ff, sin_ff;
   logic [COORD_BITS-1:0]       center_x_ff, center_y_ff;
   logic [COORD_BITS:0]         width_ff, height_ff;
   logic [COORD_BITS+1:0]       stride_ff;
   logic                        wrap_ff;

   logic              req_take, pop, front_valid, queue_not_empty;
   logic [VW-1:0]     front_xs, front_ys, head_xs, head_ys;
   logic [CRD_W-1:0]  reserved_ff, reserved_in;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cos_ff      <= COS_RESET;
         sin_ff      <= '0;
         center_x_ff <= '0;
         center_y_ff <= '0;
         width_ff    <= (COORD_BITS+1)'(DIM_RESET);
         height_ff   <= (COORD_BITS+1)'(DIM_RESET);
         stride_ff   <= (COORD_BITS+2)'(STRIDE_RESET);
         wrap_ff     <= 1'b0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_COS_SCALED:   cos_ff      <= csr_data;
            CSR_SIN_SCALED:   sin_ff      <= csr_data;
            CSR_CENTER_X:     center_x_ff <= csr_data[COORD_BITS-1:0];
            CSR_CENTER_Y:     center_y_ff <= csr_data[COORD_BITS-1:0];
            CSR_IMAGE_WIDTH:  width_ff    <= csr_data[COORD_BITS:0];
            CSR_IMAGE_HEIGHT: height_ff   <= csr_data[COORD_BITS:0];
            CSR_ROW_STRIDE:   stride_ff   <= csr_data[COORD_BITS+1:0];
            CSR_WRAP_MODE:    wrap_ff     <= csr_data[0];
            default: ;
         endcase
      end
   end

   // credits: every accepted beat holds a queue slot until the back end takes it
   assign req_stall = (reserved_ff == CRD_W'(QUEUE_DEPTH));
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      reserved_in = reserved_ff;
      if (req_take && !pop) reserved_in = reserved_ff + 1'b1;
      else if (pop && !req_take) reserved_in = reserved_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reserved_ff <= '0;
      end else begin
         reserved_ff <= reserved_in;
      end
   end

   rzsm_front #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS),
      .VW         (VW)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cos_scaled (cos_ff),
      .sin_scaled (sin_ff),
      .center_x   (center_x_ff),
      .center_y   (center_y_ff),
      .in_valid   (req_take),
      .dest_x     (req_dest_x),
      .dest_y     (req_dest_y),
      .out_valid  (front_valid),
      .xs         (front_xs),
      .ys         (front_ys)
   );

   rzsm_queue #(
      .WIDTH (2*VW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_valid),
      .push_data ({front_xs, front_ys}),
      .pop       (pop),
      .not_empty (queue_not_empty),
      .head_data ({head_xs, head_ys})
   );

   rzsm_back #(
      .COORD_BITS (COORD_BITS),
      .VW         (VW)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .image_width  (width_ff),
      .image_height (height_ff),
      .row_stride   (stride_ff),
      .wrap_mode    (wrap_ff),
      .in_valid     (queue_not_empty),
      .xs           (head_xs),
      .ys           (head_ys),
      .in_take      (pop),
      .out_valid    (rsp_valid),
      .out_stall    (rsp_stall),
      .src_x        (rsp_src_x),
      .src_y        (rsp_src_y),
      .src_address  (rsp_src_address),
      .use_fill     (rsp_use_fill)
   );

   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      reserved_ff <= CRD_W'(QUEUE_DEPTH))
      else $error("credit count above queue depth");

   a_fill_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_use_fill |->
         rsp_src_x == '0 && rsp_src_y == '0 && rsp_src_address == '0)
      else $error("fill beat carries a nonzero coordinate");

   a_wrap_no_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && wrap_ff && $stable(wrap_ff) |-> !rsp_use_fill)
      else $error("fill flag raised in wrap mode");

endmodule
`default_nettype wire
